// File: rtl/bpam_pkg.sv
// shared constants for the buzzer pin audio model: register indexes and field widths
package bpam_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_AMPLITUDE = 3'd3;

  // field widths
  localparam int DEC_W   = 16;
  localparam int AMP_W   = 14;
  localparam int AUDIO_W = 16;
  localparam int Y_W     = 20;
  localparam int CNT_W   = 16;
  localparam int PER_W   = 20;

  // register reset values
  localparam logic [DEC_W-1:0] DECIMATION_RST = 16'd45;
  localparam logic [AMP_W-1:0] HALF_AMP_RST   = 14'd16383;

  // operating modes
  localparam logic MODE_PASSIVE = 1'b0;
  localparam logic MODE_TONE    = 1'b1;

endpackage

// File: rtl/buzzer_pin_audio_model.sv
// buzzer pin audio model: decimated band-pass filter and tone period averaging
//
//   channel  ports                                 dir  beat contents
//   cfg      cfg_valid/cfg_ready                   in   cfg_index, cfg_data
//   in       in_valid/in_ready                     in   in_pin_level (one pin tick)
//   out      out_valid/out_ready                   out  out_audio_sample, out_tone_period
//
// One pin tick is taken per cycle while in_ready is high. The filter step (three
// products, sum, round and clamp) runs in the cycle a sampling tick is accepted and
// lands in the output register, so the filter recursion closes within that cycle and
// the result beat is offered the cycle after the sampling tick.
// Reset (rst_n low, synchronous) restores register defaults, loads the tick counter
// with the default decimation so the first tick samples, and clears filter and tone state.
// A pending result in the output register stalls input only when out_ready is low.
// cfg_ready is always high.
module buzzer_pin_audio_model #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bpam_pkg::AUDIO_W-1:0] out_audio_sample,
  output logic [bpam_pkg::PER_W-1:0]      out_tone_period
);
  import bpam_pkg::*;

  // coefficient format, unsigned, one integer bit
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int ACC_W  = COEF_FRAC_BITS + 24;
  localparam logic [COEF_W-1:0] COEF_B =
    COEF_W'(((64'd7837 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_A1 =
    COEF_W'(((64'd1196 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] COEF_A2 =
    COEF_W'(((64'd2068 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(524288);
  localparam logic signed [Y_W-1:0]   AUD_MAX = Y_W'(32767);
  localparam logic signed [Y_W-1:0]   AUD_MIN = -Y_W'(32768);

  // configuration registers
  logic             mode_r;
  logic             active_high_r;
  logic [DEC_W-1:0] decimation_r;
  logic [AMP_W-1:0] half_amp_r;

  // block state
  logic [DEC_W-1:0]         tick_count_r, tick_count_nxt;
  logic signed [AUDIO_W-1:0] in_d1_r, in_d2_r;
  logic signed [Y_W-1:0]    out_d1_r, out_d2_r;
  logic                     prev_level_r;
  logic [CNT_W-1:0]         edge_cnt_r;
  logic [PER_W-1:0]         period_avg_r, period_avg_nxt;

  // output register
  logic                      out_valid_r;
  logic signed [AUDIO_W-1:0] audio_r, audio_nxt;
  logic [PER_W-1:0]          period_r, period_nxt;

  logic             accept;
  logic [DEC_W:0]   tick_inc;
  logic             sample;
  logic             produce;
  logic             pos;
  logic signed [AUDIO_W-1:0] x_val;
  logic signed [AUDIO_W:0]   in_diff;
  logic signed [ACC_W-1:0]   prod_b, prod_a1, prod_a2, acc, acc_sh;
  logic signed [Y_W-1:0]     y_val;
  logic                      rising;
  logic [PER_W:0]            avg_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  // tick decimation
  assign tick_inc       = {1'b0, tick_count_r} + (DEC_W+1)'(1);
  assign sample         = tick_inc > {1'b0, decimation_r};
  assign tick_count_nxt = sample ? '0 : tick_inc[DEC_W-1:0];

  // passive mode: filter input level and band-pass step
  assign pos     = active_high_r ? in_pin_level : !in_pin_level;
  assign x_val   = pos ? $signed({2'b00, half_amp_r}) : -$signed({2'b00, half_amp_r});
  assign in_diff = {in_d1_r[AUDIO_W-1], in_d1_r} - {in_d2_r[AUDIO_W-1], in_d2_r};
  assign prod_b  = ACC_W'($signed({1'b0, COEF_B})) * ACC_W'(in_diff);
  assign prod_a1 = ACC_W'($signed({1'b0, COEF_A1})) * ACC_W'(out_d1_r);
  assign prod_a2 = ACC_W'($signed({1'b0, COEF_A2})) * ACC_W'(out_d2_r);
  assign acc     = prod_b + prod_a1 - prod_a2 + RND_HALF;
  assign acc_sh  = acc >>> COEF_FRAC_BITS;

  // clamp to filter state width
  always_comb begin
    if (acc_sh > Y_MAX) begin
      y_val = Y_MAX[Y_W-1:0];
    end else if (acc_sh < Y_MIN) begin
      y_val = Y_MIN[Y_W-1:0];
    end else begin
      y_val = acc_sh[Y_W-1:0];
    end
  end

  // tone mode: rising edge and running average
  assign rising         = !prev_level_r && in_pin_level;
  assign avg_sum        = {1'b0, period_avg_r} + {1'b0, edge_cnt_r, 4'b0000};
  assign period_avg_nxt = avg_sum[PER_W:1];

  // result selection
  always_comb begin
    produce    = 1'b0;
    audio_nxt  = '0;
    period_nxt = '0;
    if (sample) begin
      if (mode_r == MODE_PASSIVE) begin
        produce = 1'b1;
        if (y_val > AUD_MAX) begin
          audio_nxt = AUD_MAX[AUDIO_W-1:0];
        end else if (y_val < AUD_MIN) begin
          audio_nxt = AUD_MIN[AUDIO_W-1:0];
        end else begin
          audio_nxt = y_val[AUDIO_W-1:0];
        end
      end else begin
        produce    = rising;
        period_nxt = period_avg_nxt;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_PASSIVE;
      active_high_r <= 1'b1;
      decimation_r  <= DECIMATION_RST;
      half_amp_r    <= HALF_AMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:           mode_r        <= cfg_data[0];
        CFG_ACTIVE_HIGH:    active_high_r <= cfg_data[0];
        CFG_DECIMATION:     decimation_r  <= cfg_data[DEC_W-1:0];
        CFG_HALF_AMPLITUDE: half_amp_r    <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // tick counter and filter / tone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= DECIMATION_RST;
      in_d1_r      <= '0;
      in_d2_r      <= '0;
      out_d1_r     <= '0;
      out_d2_r     <= '0;
      prev_level_r <= 1'b0;
      edge_cnt_r   <= '0;
      period_avg_r <= '0;
    end else if (accept) begin
      tick_count_r <= tick_count_nxt;
      if (sample) begin
        if (mode_r == MODE_PASSIVE) begin
          in_d2_r  <= in_d1_r;
          in_d1_r  <= x_val;
          out_d2_r <= out_d1_r;
          out_d1_r <= y_val;
        end else begin
          prev_level_r <= in_pin_level;
          if (rising) begin
            period_avg_r <= period_avg_nxt;
            edge_cnt_r   <= CNT_W'(1);
          end else if (edge_cnt_r != {CNT_W{1'b1}}) begin
            edge_cnt_r <= edge_cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      audio_r  <= audio_nxt;
      period_r <= period_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_audio_sample = audio_r;
  assign out_tone_period  = period_r;

endmodule

// File: tb/sv/tb_buzzer_pin_audio_model.sv
`timescale 1ns / 100ps
// self-checking testbench for the buzzer pin audio model with its own filter and tone predictor
module tb_buzzer_pin_audio_model;
  import bpam_pkg::*;

  localparam int     FRAC_BITS   = 14;
  localparam longint TAP_B       = ((longint'(7837) << FRAC_BITS) + 5000) / 10000;
  localparam longint TAP_A1      = ((longint'(1196) << FRAC_BITS) + 500) / 1000;
  localparam longint TAP_A2      = ((longint'(2068) << FRAC_BITS) + 5000) / 10000;
  localparam longint Y_MAX       = (longint'(1) << (Y_W - 1)) - 1;
  localparam longint AUDIO_MAX   = (longint'(1) << (AUDIO_W - 1)) - 1;
  localparam int     EDGE_MAX    = (1 << CNT_W) - 1;
  localparam int     STALL_LIMIT = 500;
  localparam int     RANDOM_TICKS = 1550;
  localparam int     CALM_TICKS  = 250;
  localparam int     MAX_REPORTS = 40;
  localparam int     NROWS       = 28;

  // register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic signed [AUDIO_W-1:0] audio;
    logic [PER_W-1:0]          period;
  } beat_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic                      lvl;
    logic                      typed;
    logic signed [AUDIO_W-1:0] w_audio;
    logic [PER_W-1:0]          w_period;
  } row_t;

  // directed script: typed results only where they are obvious
  localparam row_t SCRIPT [NROWS] = '{
    '{ROW_TICK,  '0, '0, 1'b1, 1'b1, '0, '0},  // first tick after reset samples, filter empty
    '{ROW_WRITE, CFG_DECIMATION, 16'd0, 1'b0, 1'b0, '0, '0},  // sample every tick
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_ACTIVE_HIGH, 16'd0, 1'b0, 1'b0, '0, '0},  // inverted pin
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_HALF_AMPLITUDE, 16'd0, 1'b0, 1'b0, '0, '0},  // zero drive
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_HALF_AMPLITUDE, 16'hFFFF, 1'b0, 1'b0, '0, '0},  // masked to 14 bits
    '{ROW_WRITE, CFG_IDX_SPARE, 16'hFFFF, 1'b0, 1'b0, '0, '0},  // ignored index
    '{ROW_WRITE, CFG_MODE, 16'(MODE_TONE), 1'b0, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b1, '0, '0},  // first rising edge, zero count
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_DECIMATION, 16'd20, 1'b0, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_DECIMATION, 16'd2, 1'b0, 1'b0, '0, '0},  // now below tick count
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},  // samples at once, rising edge
    '{ROW_WRITE, CFG_MODE, 16'(MODE_PASSIVE), 1'b0, 1'b0, '0, '0},  // filter state kept
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0, '0},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_pin_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [AUDIO_W-1:0] out_audio_sample;
  logic [PER_W-1:0]      out_tone_period;

  // predictor copy of registers and state
  logic             m_mode;
  logic             m_active;
  logic [DEC_W-1:0] m_dec;
  logic [AMP_W-1:0] m_half;
  int unsigned      m_tick;
  longint           m_x1, m_x2, m_y1, m_y2;
  logic             m_prev;
  int unsigned      m_edges;
  logic [PER_W-1:0] m_avg;

  beat_t pending_beats[$];
  int    errors = 0;
  int    idle_pct = 0;
  bit    calm = 1'b0;
  int    stall_left = 0;
  int    quiet_cycles = 0;

  buzzer_pin_audio_model #(.COEF_FRAC_BITS(FRAC_BITS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_audio_sample (out_audio_sample),
    .out_tone_period  (out_tone_period)
  );

  always #4 clk = ~clk;

  // predictor: reset values
  function automatic void reset_model();
    m_mode   = MODE_PASSIVE;
    m_active = 1'b1;
    m_dec    = DECIMATION_RST;
    m_half   = HALF_AMP_RST;
    m_tick   = 32'(DECIMATION_RST);
    m_x1 = 0; m_x2 = 0; m_y1 = 0; m_y2 = 0;
    m_prev   = 1'b0;
    m_edges  = 0;
    m_avg    = '0;
  endfunction

  // predictor: register write, values masked to register width
  function automatic void write_model(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MODE:           m_mode = data[0];
      CFG_ACTIVE_HIGH:    m_active = data[0];
      CFG_DECIMATION:     m_dec = data[DEC_W-1:0];
      CFG_HALF_AMPLITUDE: m_half = data[AMP_W-1:0];
      default: ;
    endcase
  endfunction

  // predictor: one pin tick, returns 1 when a result beat is due
  function automatic bit filter_or_time_tick(input logic lvl, output beat_t res);
    longint      x, acc, y, a;
    int unsigned sum;
    res = '0;
    if (m_tick + 1 <= m_dec) begin
      m_tick = m_tick + 1;
      return 1'b0;
    end
    m_tick = 0;
    if (m_mode == MODE_PASSIVE) begin
      x = (lvl ^ ~m_active) ? longint'(m_half) : -longint'(m_half);
      acc = TAP_B * (m_x1 - m_x2) + TAP_A1 * m_y1 - TAP_A2 * m_y2;
      y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (y > Y_MAX) y = Y_MAX;
      if (y < -Y_MAX - 1) y = -Y_MAX - 1;
      a = y;
      if (a > AUDIO_MAX) a = AUDIO_MAX;
      if (a < -AUDIO_MAX - 1) a = -AUDIO_MAX - 1;
      m_x2 = m_x1;
      m_x1 = x;
      m_y2 = m_y1;
      m_y1 = y;
      res.audio = a[AUDIO_W-1:0];
      return 1'b1;
    end
    // tone mode: raw pin, result on sampled rising edge only
    if (!m_prev && lvl) begin
      sum = m_avg + (m_edges << 4);
      sum = sum >> 1;
      m_avg = sum[PER_W-1:0];
      m_edges = 0;
      res.period = m_avg;
      m_prev = lvl;
      m_edges = m_edges + 1;
      return 1'b1;
    end
    m_prev = lvl;
    if (m_edges < EDGE_MAX) m_edges = m_edges + 1;
    return 1'b0;
  endfunction

  // one register write beat, block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    write_model(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one pin tick beat, with an optional idle burst ahead of it
  task automatic send_tick(input logic lvl, input bit typed, input beat_t want);
    beat_t res;
    int    gap;
    if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= lvl;
    do @(posedge clk); while (!in_ready);
    if (filter_or_time_tick(lvl, res)) pending_beats.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // hold the sender until every due beat is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest due beat
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        if (errors < MAX_REPORTS)
          $error("unexpected beat: audio_sample %0d, tone_period %0d",
                 out_audio_sample, out_tone_period);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_audio_sample !== want.audio) begin
          if (errors < MAX_REPORTS)
            $error("audio_sample: expected %0d, actual %0d", want.audio, out_audio_sample);
          errors++;
        end
        if (out_tone_period !== want.period) begin
          if (errors < MAX_REPORTS)
            $error("tone_period: expected %0d, actual %0d", want.period, out_tone_period);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int    sent, n, hp, span, phase;
    logic  lvl;
    bit    noisy;
    beat_t want;

    reset_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed script
    idle_pct = 20;
    for (int i = 0; i < NROWS; i++) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        settle();
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        want.audio  = SCRIPT[i].w_audio;
        want.period = SCRIPT[i].w_period;
        send_tick(SCRIPT[i].lvl, SCRIPT[i].typed, want);
      end
    end

    // tone mode with a long low stretch between edges
    settle();
    idle_pct = 3;
    write_reg(CFG_MODE, 16'(MODE_TONE));
    write_reg(CFG_DECIMATION, 16'd0);
    send_tick(1'b0, 1'b0, '0);
    send_tick(1'b1, 1'b0, '0);
    for (int k = 0; k < 200; k++) send_tick(1'b0, 1'b0, '0);
    send_tick(1'b1, 1'b0, '0);
    send_tick(1'b0, 1'b0, '0);
    send_tick(1'b1, 1'b0, '0);

    // widest decimation with full drive: no sample within a short run
    settle();
    write_reg(CFG_MODE, 16'(MODE_PASSIVE));
    write_reg(CFG_ACTIVE_HIGH, 16'd1);
    write_reg(CFG_HALF_AMPLITUDE, 16'h3FFF);
    write_reg(CFG_DECIMATION, 16'hFFFF);
    for (int k = 0; k < 40; k++) send_tick(1'(k >> 3), 1'b0, '0);
    settle();
    write_reg(CFG_DECIMATION, 16'd1);

    // random phases: new settings, then square waves or noise on the pin
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      settle();
      calm = (sent >= RANDOM_TICKS - CALM_TICKS);
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 15;
        default: idle_pct = 35;
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(CFG_MODE, 16'($urandom()));
      if ($urandom_range(0, 1) != 0) write_reg(CFG_ACTIVE_HIGH, 16'($urandom()));
      if ($urandom_range(0, 1) != 0)
        write_reg(CFG_DECIMATION, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(6, 30))
                                                               : 16'($urandom_range(0, 5)));
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_HALF_AMPLITUDE, 16'h0000);
          1:       write_reg(CFG_HALF_AMPLITUDE, 16'hFFFF);
          default: write_reg(CFG_HALF_AMPLITUDE, 16'($urandom()));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_SPARE - 3'($urandom_range(0, 3)), 16'($urandom()));

      n = $urandom_range(40, 120);
      hp = $urandom_range(1, 16);
      span = hp * (int'(m_dec) + 1);
      phase = $urandom_range(0, 2 * span - 1);
      noisy = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n; k++) begin
        if (noisy) begin
          lvl = 1'($urandom_range(0, 1));
        end else begin
          lvl = 1'(((k + phase) / span) % 2);
          if ($urandom_range(0, 39) == 0) lvl = ~lvl;
        end
        send_tick(lvl, 1'b0, '0);
      end
      sent += n;
    end

    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bpam_pkg.sv
rtl/buzzer_pin_audio_model.sv
tb/sv/tb_buzzer_pin_audio_model.sv
